/* src/xoshiro_pkg.sv */
// Shared types and constants for the xoshiro128** random source.
// No dependencies; xoshiro_step, the top level and the testbench files refer to this package.
package xoshiro_pkg;

  // request codes carried in req_type
  typedef enum logic [2:0] {
    REQ_SEED    = 3'd0,
    REQ_STIR    = 3'd1,
    REQ_RAW     = 3'd2,
    REQ_BOUNDED = 3'd3,
    REQ_RANGE   = 3'd4,
    REQ_PERCENT = 3'd5
  } req_kind_t;

  // commands to the step unit
  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_SEED = 2'd1,
    CMD_STIR = 2'd2,
    CMD_STEP = 2'd3
  } step_cmd_t;

  typedef struct packed {
    step_cmd_t   cmd;
    logic [31:0] seed;
    logic [7:0]  line;
    logic [15:0] timer;
  } step_ctrl_t;

  // reset values of the state words
  localparam logic [31:0] RST_A = 32'h9E37_79B9;
  localparam logic [31:0] RST_B = 32'h243F_6A88;
  localparam logic [31:0] RST_C = 32'hB7E1_5162;
  localparam logic [31:0] RST_D = 32'hDEAD_BEEF;

  // seed mixing constants
  localparam logic [31:0] SEED_A = 32'h9E37_79B9;
  localparam logic [31:0] SEED_B = 32'h243F_6A88;
  localparam logic [31:0] SEED_C = 32'hB7E1_5162;
  localparam logic [31:0] SEED_D = 32'h1BAD_B002;

  localparam logic [31:0] STIR_MULT   = 32'h2545_F491;
  localparam logic [31:0] PERCENT_MAX = 32'd100;

  localparam int WARMUP_ROUNDS_DEF = 16;

endpackage

/* src/xoshiro_req_if.sv */
// Request channel of the xoshiro128** random source.
// Depends on nothing; one word per valid/ready handshake.
interface xoshiro_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [31:0]        seed_value;
  logic [7:0]         line_count;
  logic [15:0]        timer_count;
  logic [31:0]        bound_n;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;
  logic [6:0]         percent;

  modport source (
    output valid, req_type, seed_value, line_count, timer_count,
           bound_n, range_low, range_high, percent,
    input  ready
  );
  modport sink (
    input  valid, req_type, seed_value, line_count, timer_count,
           bound_n, range_low, range_high, percent,
    output ready
  );
endinterface

/* src/xoshiro_rsp_if.sv */
// Result channel of the xoshiro128** random source.
// Depends on nothing; one word per valid/ready handshake.
interface xoshiro_rsp_if;
  logic               valid;
  logic               ready;
  logic [31:0]        random_word;
  logic signed [31:0] range_value;
  logic               chance_hit;

  modport source (
    output valid, random_word, range_value, chance_hit,
    input  ready
  );
  modport sink (
    input  valid, random_word, range_value, chance_hit,
    output ready
  );
endinterface

/* src/xoshiro_step.sv */
// xoshiro128** state words and the shared step unit (seed, stir, step).
// Depends on xoshiro_pkg.
module xoshiro_step (
  input  logic                    clk,
  input  logic                    rst,
  input  xoshiro_pkg::step_ctrl_t ctrl,
  output logic [31:0]             word
);

  logic [31:0] a, b, c, d;
  logic [31:0] a_next, b_next, c_next, d_next;

  // scrambler: rotl(b * 5, 7) * 9
  logic [31:0] b5, b5r;
  logic [31:0] c1, d1, d_rot;
  logic [31:0] mix;

  assign b5   = b + {b[29:0], 2'b00};
  assign b5r  = {b5[24:0], b5[31:25]};
  assign word = b5r + {b5r[28:0], 3'b000};

  assign c1    = c ^ a;
  assign d1    = d ^ b;
  assign d_rot = {d1[20:0], d1[31:21]};
  assign mix   = 32'({24'd0, ctrl.line} * xoshiro_pkg::STIR_MULT);

  always_comb begin
    a_next = a;
    b_next = b;
    c_next = c;
    d_next = d;
    case (ctrl.cmd)
      xoshiro_pkg::CMD_SEED: begin
        a_next = ctrl.seed ^ xoshiro_pkg::SEED_A;
        b_next = {ctrl.seed[18:0], 13'd0} ^ xoshiro_pkg::SEED_B;
        c_next = {7'd0, ctrl.seed[31:7]} ^ xoshiro_pkg::SEED_C;
        d_next = {ctrl.seed[26:0], 5'd0} ^ xoshiro_pkg::SEED_D;
      end
      xoshiro_pkg::CMD_STIR: begin
        a_next = a ^ mix;
        c_next = c + {16'd0, ctrl.timer[15:1], 1'b1};
      end
      xoshiro_pkg::CMD_STEP: begin
        a_next = a ^ d1;
        b_next = b ^ c1;
        c_next = c1 ^ {b[22:0], 9'd0};
        d_next = d_rot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a <= xoshiro_pkg::RST_A;
      b <= xoshiro_pkg::RST_B;
      c <= xoshiro_pkg::RST_C;
      d <= xoshiro_pkg::RST_D;
    end else begin
      a <= a_next;
      b <= b_next;
      c <= c_next;
      d <= d_next;
    end
  end

endmodule

/* src/xoshiro_mulhi.sv */
// Registered 32x32 multiply-high for bounded draws.
// Depends on nothing.
module xoshiro_mulhi (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic [31:0] hi
);

  logic [63:0] prod;

  assign prod = {32'd0, x} * {32'd0, y};

  always_ff @(posedge clk) begin
    if (en) begin
      hi <= prod[63:32];
    end
  end

endmodule

/* src/xoshiro128_random_source.sv */
// Top level of the xoshiro128** random source: sequencer and result register.
// Depends on xoshiro_pkg, xoshiro_req_if, xoshiro_rsp_if, xoshiro_step,
// xoshiro_mulhi.
//
//  channel  dir  iface           payload
//  -------  ---  --------------  -----------------------------------------------
//  req      in   xoshiro_req_if  req_type, seed_value, line_count, timer_count,
//                                bound_n, range_low, range_high, percent
//  rsp      out  xoshiro_rsp_if  random_word, range_value, chance_hit
//
//  Sequence: a seed word is loaded in its accept cycle, then the step unit runs
//  WARMUP_ROUNDS steps in ST_WARM before ready comes back. A stir mixes in its
//  accept cycle and steps once in ST_WARM. A draw steps in ST_DRAW (not at zero
//  width), takes the multiply-high in ST_MUL, forms the result in ST_DONE; the
//  next request is accepted only after those three sequencer stages, in ST_IDLE.
//  Reset (rst, synchronous) restores the fixed state words and empties rsp.
//  A result waits in the output register; a stalled rsp holds the sequencer
//  only when a second result is ready to be written.
module xoshiro128_random_source #(
  parameter int WARMUP_ROUNDS = xoshiro_pkg::WARMUP_ROUNDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  xoshiro_req_if.sink   req,
  xoshiro_rsp_if.source rsp
);

  localparam int CW = (WARMUP_ROUNDS < 1) ? 1 : $clog2(WARMUP_ROUNDS + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WARM = 5'b00010,
    ST_DRAW = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] wcnt;          // steps left in the warm-up loop
  logic [2:0]    kind;          // request code of the draw in flight
  logic [31:0]   bound;         // multiply-high operand
  logic [31:0]   lo;
  logic [6:0]    pct;
  logic          skip;          // zero width: no step, result from zero
  logic [31:0]   word_q;        // drawn word

  xoshiro_pkg::step_ctrl_t ctrl;
  logic [31:0] step_word;
  logic [31:0] prod_hi;
  logic        accept;
  logic        slot_free;
  logic [31:0] n_in;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign slot_free = !rsp.valid || rsp.ready;

  // width of the draw for the incoming request
  always_comb begin
    case (req.req_type)
      xoshiro_pkg::REQ_BOUNDED: n_in = req.bound_n;
      xoshiro_pkg::REQ_RANGE:   n_in = 32'(req.range_high - req.range_low) + 32'd1;
      xoshiro_pkg::REQ_PERCENT: n_in = xoshiro_pkg::PERCENT_MAX;
      default:                  n_in = 32'd1;
    endcase
  end

  // step unit command
  always_comb begin
    ctrl.cmd   = xoshiro_pkg::CMD_HOLD;
    ctrl.seed  = req.seed_value;
    ctrl.line  = req.line_count;
    ctrl.timer = req.timer_count;
    if (accept && req.req_type == xoshiro_pkg::REQ_SEED) begin
      ctrl.cmd = xoshiro_pkg::CMD_SEED;
    end else if (accept && req.req_type == xoshiro_pkg::REQ_STIR) begin
      ctrl.cmd = xoshiro_pkg::CMD_STIR;
    end else if (state == ST_WARM || (state == ST_DRAW && !skip)) begin
      ctrl.cmd = xoshiro_pkg::CMD_STEP;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.req_type == xoshiro_pkg::REQ_SEED) begin
            state_next = (WARMUP_ROUNDS > 0) ? ST_WARM : ST_IDLE;
          end else if (req.req_type == xoshiro_pkg::REQ_STIR) begin
            state_next = ST_WARM;
          end else if (req.req_type inside {[xoshiro_pkg::REQ_RAW :
                                              xoshiro_pkg::REQ_PERCENT]}) begin
            state_next = ST_DRAW;
          end
        end
      end
      ST_WARM: if (wcnt == CW'(1)) state_next = ST_IDLE;
      ST_DRAW: state_next = ST_MUL;
      ST_MUL:  state_next = ST_DONE;
      ST_DONE: if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wcnt  <= '0;
    end else begin
      state <= state_next;
      if (accept && req.req_type == xoshiro_pkg::REQ_SEED) begin
        wcnt <= CW'(WARMUP_ROUNDS);
      end else if (accept && req.req_type == xoshiro_pkg::REQ_STIR) begin
        wcnt <= CW'(1);
      end else if (state == ST_WARM) begin
        wcnt <= wcnt - CW'(1);
      end
    end
  end

  // draw operands, captured at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      kind  <= req.req_type;
      bound <= n_in;
      lo    <= req.range_low;
      pct   <= req.percent;
      skip  <= (req.req_type != xoshiro_pkg::REQ_RAW) && (n_in == 32'd0);
    end
    if (state == ST_DRAW) begin
      word_q <= skip ? 32'd0 : step_word;
    end
  end

  xoshiro_step u_step (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .word (step_word)
  );

  xoshiro_mulhi u_mulhi (
    .clk (clk),
    .en  (state == ST_MUL),
    .x   (word_q),
    .y   (bound),
    .hi  (prod_hi)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_DONE && slot_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && slot_free) begin
      rsp.random_word <= 32'd0;
      rsp.range_value <= 32'sd0;
      rsp.chance_hit  <= 1'b0;
      case (kind)
        xoshiro_pkg::REQ_RAW:     rsp.random_word <= word_q;
        xoshiro_pkg::REQ_BOUNDED: rsp.random_word <= prod_hi;
        xoshiro_pkg::REQ_RANGE:   rsp.range_value <= lo + prod_hi;
        xoshiro_pkg::REQ_PERCENT: rsp.chance_hit  <= (prod_hi < {25'd0, pct});
        default: begin
        end
      endcase
    end
  end

  // checks
  a_warm_cnt: assert property (@(posedge clk) disable iff (rst)
    state == ST_WARM |-> wcnt != '0)
    else $error("warm-up loop running with zero count");

  a_draw_enters: assert property (@(posedge clk) disable iff (rst)
    accept && (req.req_type == xoshiro_pkg::REQ_RAW ||
               req.req_type == xoshiro_pkg::REQ_BOUNDED ||
               req.req_type == xoshiro_pkg::REQ_RANGE ||
               req.req_type == xoshiro_pkg::REQ_PERCENT) |=> state == ST_DRAW)
    else $error("draw request did not start a draw");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_DONE))
    else $error("result appeared without a finished draw");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !rsp.valid |=> rsp.valid)
    else $error("finished draw not written to the result register");

endmodule

/* tb/sv/draw_checker.sv */
`timescale 1ns / 100ps
// Result checker for xoshiro128_random_source: tracks the generator state on
// every accepted request word and compares each result word in order.
// Depends on xoshiro_pkg, xoshiro_req_if and xoshiro_rsp_if.
module draw_checker #(
  parameter int WARMUP = xoshiro_pkg::WARMUP_ROUNDS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  xoshiro_req_if req,
  xoshiro_rsp_if rsp,
  output int     pending,
  output int     fails
);
  import xoshiro_pkg::*;

  typedef struct packed {
    logic [31:0]        word;
    logic signed [31:0] rval;
    logic               hit;
  } draw_t;

  logic [31:0] st_a, st_b, st_c, st_d;
  draw_t       due_draws[$];
  int          err_cnt = 0;

  // one xoshiro128** step, returns the scrambled output
  function automatic logic [31:0] next_word();
    logic [31:0] mul5, res, t;
    mul5 = st_b * 32'd5;
    res  = {mul5[24:0], mul5[31:25]} * 32'd9;
    t    = st_b << 9;
    st_c ^= st_a;
    st_d ^= st_b;
    st_b ^= st_c;
    st_a ^= st_d;
    st_c ^= t;
    st_d = {st_d[20:0], st_d[31:21]};
    return res;
  endfunction

  // multiply-high scaling; a zero bound leaves the state alone
  function automatic logic [31:0] scaled_draw(input logic [31:0] n);
    logic [63:0] prod;
    if (n == 32'd0) return 32'd0;
    prod = 64'(next_word()) * 64'(n);
    return prod[63:32];
  endfunction

  function automatic bit apply_request(input logic [2:0] kind, input logic [31:0] seed,
                                       input logic [7:0] line, input logic [15:0] timer,
                                       input logic [31:0] bound, input logic [31:0] lo,
                                       input logic [31:0] hi, input logic [6:0] pct,
                                       output draw_t d);
    logic [31:0] span;
    d = '0;
    case (kind)
      REQ_SEED: begin
        st_a = seed ^ SEED_A;
        st_b = (seed << 13) ^ SEED_B;
        st_c = (seed >> 7) ^ SEED_C;
        st_d = (seed << 5) ^ SEED_D;
        repeat (WARMUP) void'(next_word());
        return 1'b0;
      end
      REQ_STIR: begin
        st_a ^= {24'd0, line} * STIR_MULT;
        st_c += {16'd0, timer} | 32'd1;
        void'(next_word());
        return 1'b0;
      end
      REQ_RAW:     d.word = next_word();
      REQ_BOUNDED: d.word = scaled_draw(bound);
      REQ_RANGE: begin
        span = hi - lo + 32'd1;
        // zero span is the full 32-bit range: no step
        d.rval = (span == 32'd0) ? lo : lo + scaled_draw(span);
      end
      REQ_PERCENT: d.hit = scaled_draw(PERCENT_MAX) < {25'd0, pct};
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    draw_t want, got;
    if (rst) begin
      st_a = RST_A;
      st_b = RST_B;
      st_c = RST_C;
      st_d = RST_D;
      due_draws.delete();
    end else begin
      if (req.valid && req.ready) begin
        if (apply_request(req.req_type, req.seed_value, req.line_count, req.timer_count,
                          req.bound_n, req.range_low, req.range_high, req.percent, want))
          due_draws.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.random_word, rsp.range_value, rsp.chance_hit};
        if (due_draws.size() == 0) begin
          $display("%0t: result word with none due: word=%h range=%0d hit=%b",
                   $time, got.word, got.rval, got.hit);
          err_cnt++;
        end else begin
          want = due_draws.pop_front();
          if (got.word !== want.word) begin
            $display("%0t: random_word exp %h got %h", $time, want.word, got.word);
            err_cnt++;
          end
          if (got.rval !== want.rval) begin
            $display("%0t: range_value exp %0d got %0d", $time, want.rval, got.rval);
            err_cnt++;
          end
          if (got.hit !== want.hit) begin
            $display("%0t: chance_hit exp %b got %b", $time, want.hit, got.hit);
            err_cnt++;
          end
        end
      end
    end
    pending <= due_draws.size();
    fails   <= err_cnt;
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for xoshiro128_random_source: clock, reset, request and
// result drivers, verdict. Depends on xoshiro_pkg, both channel interfaces,
// the block itself and draw_checker.
module tb_top;
  import xoshiro_pkg::*;

  localparam int WARMUP       = WARMUP_ROUNDS_DEF;
  localparam int RANDOM_WORDS = 850;
  localparam int PHASES       = 8;
  // longest quiet stretch in a good run: a seed warm-up plus geometric gaps
  // at 83% on one side at a time; this limit is generous
  localparam int IDLE_LIMIT   = 2000;
  // room for a late draw through its sequencer states or a seed warm-up after the drain
  localparam int DRAIN_CYCLES = 2 * WARMUP + 8;

  // request codes the block treats as no-ops
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] seed;
    logic [7:0]  line;
    logic [15:0] timer;
    logic [31:0] bound;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [6:0]  pct;
  } req_word_t;

  logic clk;
  logic rst;
  int   pending;
  int   fails;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  int   idle_cycles  = 0;

  xoshiro_req_if req_ch();
  xoshiro_rsp_if rsp_ch();

  xoshiro128_random_source #(
    .WARMUP_ROUNDS(WARMUP)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  draw_checker #(
    .WARMUP(WARMUP)
  ) u_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .pending (pending),
    .fails   (fails)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: stall at the rate set by the current phase
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // watchdog: any handshake on either channel counts as progress
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // every field random; callers then pin the ones under test
  function automatic req_word_t scatter_fields(input logic [2:0] kind);
    req_word_t w;
    w.kind  = kind;
    w.seed  = $urandom;
    w.line  = 8'($urandom);
    w.timer = 16'($urandom);
    w.bound = $urandom;
    w.lo    = $urandom;
    w.hi    = $urandom;
    w.pct   = 7'($urandom);
    return w;
  endfunction

  // Mostly draws, with seeds and stirs sprinkled in so the state keeps
  // getting reloaded and mixed. Bounds, spans and percents get pulled
  // toward their edges a quarter of the time each way.
  function automatic req_word_t random_request();
    req_word_t   w;
    int          pick;
    logic [2:0]  kind;
    pick = $urandom_range(99);
    if (pick < 4)       kind = REQ_SEED;
    else if (pick < 12) kind = REQ_STIR;
    else if (pick < 35) kind = REQ_RAW;
    else if (pick < 55) kind = REQ_BOUNDED;
    else if (pick < 75) kind = REQ_RANGE;
    else if (pick < 96) kind = REQ_PERCENT;
    else                kind = $urandom_range(1) ? REQ_SPARE_6 : REQ_SPARE_7;
    w = scatter_fields(kind);
    case ($urandom_range(3))
      0: begin
        // small bounds, short spans, percents around the whole scale
        w.bound = $urandom_range(16);
        w.hi    = w.lo + 32'($urandom_range(20));
        w.pct   = 7'($urandom_range(101));
      end
      1: begin
        // near-max bounds, span of one or the full range, percent near 100
        w.bound = ~32'($urandom_range(3));
        w.hi    = w.lo - 32'($urandom_range(1));
        w.pct   = 7'($urandom_range(98, 101));
      end
      default: ;
    endcase
    return w;
  endfunction

  // Present one request word and hold it until the block takes it. Valid
  // stays high across back-to-back words, so it gets a single assignment
  // per edge either way.
  task automatic send_word(input req_word_t w);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= w.kind;
    req_ch.seed_value  <= w.seed;
    req_ch.line_count  <= w.line;
    req_ch.timer_count <= w.timer;
    req_ch.bound_n     <= w.bound;
    req_ch.range_low   <= w.lo;
    req_ch.range_high  <= w.hi;
    req_ch.percent     <= w.pct;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  initial begin
    req_word_t w;
    int        sent;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_RAW;
    req_ch.seed_value  <= '0;
    req_ch.line_count  <= '0;
    req_ch.timer_count <= '0;
    req_ch.bound_n     <= '0;
    req_ch.range_low   <= '0;
    req_ch.range_high  <= '0;
    req_ch.percent     <= '0;
    rst                <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed words, no idling
    // first draw comes straight from the reset state
    w = scatter_fields(REQ_RAW);     send_word(w);
    // zero bound gives zero and must not step
    w = scatter_fields(REQ_BOUNDED); w.bound = 32'd0;          send_word(w);
    w = scatter_fields(REQ_BOUNDED); w.bound = 32'd1;          send_word(w);
    w = scatter_fields(REQ_BOUNDED); w.bound = 32'hFFFF_FFFF;  send_word(w);
    w = scatter_fields(REQ_BOUNDED); w.bound = 32'h8000_0000;  send_word(w);
    // full 32-bit range wraps the span to zero: low end, no step
    w = scatter_fields(REQ_RANGE);   w.lo = 32'h8000_0000; w.hi = 32'h7FFF_FFFF; send_word(w);
    w = scatter_fields(REQ_RANGE);   w.hi = w.lo;          send_word(w);
    // reversed ends: span wraps and is used as is
    w = scatter_fields(REQ_RANGE);   w.lo = 32'd5;         w.hi = -32'sd5;       send_word(w);
    w = scatter_fields(REQ_RANGE);   w.lo = 32'h7FFF_FFFF; w.hi = 32'h8000_0000; send_word(w);
    w = scatter_fields(REQ_RANGE);   w.lo = 32'hFFFF_FFFF; w.hi = 32'd0;         send_word(w);
    w = scatter_fields(REQ_RANGE);   w.lo = 32'h7FFF_FFFF; w.hi = 32'h7FFF_FFFF; send_word(w);
    // percent: zero never hits, 100 and up always hit
    w = scatter_fields(REQ_PERCENT); w.pct = 7'd0;   send_word(w);
    w = scatter_fields(REQ_PERCENT); w.pct = 7'd1;   send_word(w);
    w = scatter_fields(REQ_PERCENT); w.pct = 7'd99;  send_word(w);
    w = scatter_fields(REQ_PERCENT); w.pct = 7'd100; send_word(w);
    w = scatter_fields(REQ_PERCENT); w.pct = 7'd127; send_word(w);
    // stir at both ends of line and timer; timer 0 is forced odd
    w = scatter_fields(REQ_STIR);    w.line = 8'd0;   w.timer = 16'd0;      send_word(w);
    w = scatter_fields(REQ_STIR);    w.line = 8'hFF;  w.timer = 16'hFFFF;   send_word(w);
    w = scatter_fields(REQ_RAW);     send_word(w);
    w = scatter_fields(REQ_SEED);    w.seed = 32'd0;         send_word(w);
    w = scatter_fields(REQ_RAW);     send_word(w);
    w = scatter_fields(REQ_SEED);    w.seed = 32'hFFFF_FFFF; send_word(w);
    // unused codes change nothing; the raw draw after proves it
    w = scatter_fields(REQ_SPARE_6); send_word(w);
    w = scatter_fields(REQ_SPARE_7); send_word(w);
    w = scatter_fields(REQ_RAW);     send_word(w);

    // random words over the four idling modes, each visited twice
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
        default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
      endcase
      sent = 0;
      while (sent < RANDOM_WORDS / PHASES) begin
        w = random_request();
        send_word(w);
        // spare codes do nothing, so they don't count toward the total
        if (w.kind <= REQ_PERCENT) sent++;
      end
    end
    req_ch.valid <= 1'b0;

    // let the checker's count settle, then drain what is still due
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* xoshiro128_random_source.f */
src/xoshiro_pkg.sv
src/xoshiro_req_if.sv
src/xoshiro_rsp_if.sv
src/xoshiro_step.sv
src/xoshiro_mulhi.sv
src/xoshiro128_random_source.sv
tb/sv/draw_checker.sv
tb/sv/tb_top.sv
